### src/mmau_pkg.sv
package mmau_pkg;

    localparam int ADDR_W    = 16;
    localparam int ROM_DEPTH = 49152;
    localparam int ROM_AW    = 16;

    localparam logic [15:0] ROM_WINDOW_MASK   = 16'hC000;
    localparam logic [15:0] UPPER_WINDOW_MASK = 16'h3000;
    localparam logic [15:0] UPPER_HOLE_START  = 16'h3900;
    localparam logic [15:0] LOWER_HOLE_START  = 16'h0A00;
    localparam logic [15:0] LOWER_RAM_START   = 16'h0200;
    localparam logic [8:0]  SFR_MASK          = 9'h1FF;
    localparam logic [7:0]  ERASED_BYTE       = 8'hFF;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_BREAK = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BREAK     = 3'd1,
        STATUS_BAD_STORE = 3'd2,
        STATUS_NO_DEV    = 3'd3,
        STATUS_BAD_EXEC  = 3'd4,
        STATUS_FORWARD   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REGION_SFR,
        REGION_RAM,
        REGION_FIXED,
        REGION_ROM,
        REGION_NODEV
    } region_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_HOLD
    } state_t;

    typedef struct packed {
        region_t     region;
        logic [15:0] rom_idx;
        logic [15:0] ram_idx;
    } dec_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        word_access;
        logic        exec_access;
        logic        break_flag;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  read_data;
        logic [31:0] access_count;
        logic [8:0]  periph_address;
        logic        periph_write;
        logic        periph_word;
        logic [7:0]  periph_data;
    } rsp_t;

endpackage

### src/mmau_ram.sv
module mmau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/mmau_decode.sv
module mmau_decode #(
    parameter int ROM_START       = 16384,
    parameter int UPPER_RAM_START = 4352,
    parameter int BOOT_ROM_START  = 3072,
    parameter int RAM_BYTES       = 10240
) (
    input  logic [15:0]       address,
    output mmau_pkg::dec_t    dec
);

    logic [15:0] rom_idx;
    logic [15:0] upper_idx;
    logic [15:0] lower_idx;

    assign rom_idx   = address - 16'(ROM_START);
    assign upper_idx = address - 16'(UPPER_RAM_START);
    assign lower_idx = address - mmau_pkg::LOWER_RAM_START;

    always_comb
    begin
        dec.rom_idx = rom_idx;
        dec.ram_idx = lower_idx;
        dec.region  = mmau_pkg::REGION_NODEV;
        priority if ((address & mmau_pkg::ROM_WINDOW_MASK) != 16'h0000)
        begin
            if (address >= 16'(ROM_START) && rom_idx < 16'(mmau_pkg::ROM_DEPTH))
            begin
                dec.region = mmau_pkg::REGION_ROM;
            end
        end
        else if ((address & mmau_pkg::UPPER_WINDOW_MASK) != 16'h0000)
        begin
            dec.ram_idx = upper_idx;
            priority if (address >= mmau_pkg::UPPER_HOLE_START)
            begin
                dec.region = mmau_pkg::REGION_NODEV;
            end
            else if (address < 16'(UPPER_RAM_START))
            begin
                dec.region = mmau_pkg::REGION_FIXED;
            end
            else if (upper_idx < 16'(RAM_BYTES))
            begin
                dec.region = mmau_pkg::REGION_RAM;
            end
            else
            begin
                dec.region = mmau_pkg::REGION_NODEV;
            end
        end
        else if (address >= 16'(BOOT_ROM_START))
        begin
            dec.region = mmau_pkg::REGION_FIXED;
        end
        else if (address >= mmau_pkg::LOWER_HOLE_START)
        begin
            dec.region = mmau_pkg::REGION_NODEV;
        end
        else if (address >= mmau_pkg::LOWER_RAM_START)
        begin
            if (lower_idx < 16'(RAM_BYTES))
            begin
                dec.region = mmau_pkg::REGION_RAM;
            end
        end
        else
        begin
            dec.region = mmau_pkg::REGION_SFR;
        end
    end

endmodule

### src/memory_map_access_unit.sv
// Channel   | Direction | Handshake           | Word
// req       | in        | req_valid/req_stall | op, address, write_data, access flags
// rsp       | out       | rsp_valid/rsp_stall | status, read_data, access_count, periph
// cfg       | in        | cfg_valid/cfg_ready | profile_enable
//
// Each request is handled as one synchronous read of the breakpoint/counter
// memory and the byte memories, then decode and write-back.
// After reset the breakpoint/counter memory is cleared before any request is
// taken; cfg writes are taken during that pass.
// A stalled response is held in the output register; the next request is taken
// while it waits, and its result waits in a holding register.
module memory_map_access_unit #(
    parameter int ROM_START       = 16384,
    parameter int UPPER_RAM_START = 4352,
    parameter int BOOT_ROM_START  = 3072,
    parameter int RAM_BYTES       = 10240,
    parameter int COUNT_BITS      = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mmau_pkg::req_t req_word,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mmau_pkg::rsp_t rsp_word,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data
);

    localparam int RAM_AW = $clog2(RAM_BYTES);

    mmau_pkg::state_t state_reg;
    mmau_pkg::state_t state_next;
    logic [15:0]      clear_cnt_reg;
    logic [15:0]      clear_cnt_next;
    logic             profile_enable_reg;
    logic             profile_enable_next;
    mmau_pkg::req_t   item_reg;
    mmau_pkg::req_t   item_next;
    mmau_pkg::rsp_t   res_reg;
    mmau_pkg::rsp_t   res_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    mmau_pkg::rsp_t   rsp_word_reg;
    mmau_pkg::rsp_t   rsp_word_next;

    logic                  req_accept;
    logic                  rsp_free;
    logic [15:0]           mem_addr;
    mmau_pkg::dec_t        dec;

    logic                  prof_en;
    logic                  prof_we;
    logic [15:0]           prof_addr;
    logic [COUNT_BITS:0]   prof_wdata;
    logic [COUNT_BITS:0]   prof_rdata;
    logic [COUNT_BITS:0]   prof_wr_data;
    logic                  prof_wr_req;

    logic                  rom_en;
    logic                  rom_we;
    logic                  rom_wr_req;
    logic [7:0]            rom_rdata;

    logic                  ram_en;
    logic                  ram_we;
    logic                  ram_wr_req;
    logic [7:0]            ram_rdata;

    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [COUNT_BITS-1:0] cnt_show;
    logic [63:0]           cnt_wide;
    logic                  is_write;
    mmau_pkg::rsp_t        res_comb;

    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_word   = rsp_word_reg;

    assign mem_addr  = (state_reg == mmau_pkg::S_IDLE) ? req_word.address : item_reg.address;
    assign prof_addr = (state_reg == mmau_pkg::S_CLEAR) ? clear_cnt_reg : mem_addr;

    mmau_decode #(
        .ROM_START       (ROM_START),
        .UPPER_RAM_START (UPPER_RAM_START),
        .BOOT_ROM_START  (BOOT_ROM_START),
        .RAM_BYTES       (RAM_BYTES)
    ) u_decode (
        .address (mem_addr),
        .dec     (dec)
    );

    mmau_ram #(
        .WIDTH (COUNT_BITS + 1),
        .DEPTH (65536)
    ) u_prof_ram (
        .clk   (clk),
        .en    (prof_en),
        .we    (prof_we),
        .addr  (prof_addr),
        .wdata (prof_wdata),
        .rdata (prof_rdata)
    );

    mmau_ram #(
        .WIDTH (8),
        .DEPTH (mmau_pkg::ROM_DEPTH)
    ) u_rom (
        .clk   (clk),
        .en    (rom_en),
        .we    (rom_we),
        .addr  (dec.rom_idx[mmau_pkg::ROM_AW-1:0]),
        .wdata (item_reg.write_data),
        .rdata (rom_rdata)
    );

    mmau_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_data_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (dec.ram_idx[RAM_AW-1:0]),
        .wdata (item_reg.write_data),
        .rdata (ram_rdata)
    );

    // decode and update of the item read in the previous cycle
    assign cnt      = prof_rdata[COUNT_BITS-1:0];
    assign cnt_new  = (profile_enable_reg && !(&cnt)) ? cnt + COUNT_BITS'(1) : cnt;
    assign is_write = (item_reg.op == mmau_pkg::OP_WRITE);
    assign cnt_wide = 64'(cnt_show);

    always_comb
    begin
        res_comb     = '0;
        cnt_show     = cnt;
        prof_wr_req  = 1'b0;
        prof_wr_data = prof_rdata;
        rom_wr_req   = 1'b0;
        ram_wr_req   = 1'b0;
        unique case (item_reg.op)
            mmau_pkg::OP_LOAD:
            begin
                rom_wr_req = (dec.region == mmau_pkg::REGION_ROM);
            end
            mmau_pkg::OP_BREAK:
            begin
                prof_wr_req  = 1'b1;
                prof_wr_data = {item_reg.break_flag, cnt};
            end
            mmau_pkg::OP_READ,
            mmau_pkg::OP_WRITE:
            begin
                if (prof_rdata[COUNT_BITS])
                begin
                    res_comb.status = mmau_pkg::STATUS_BREAK;
                end
                else
                begin
                    cnt_show     = cnt_new;
                    prof_wr_req  = 1'b1;
                    prof_wr_data = {1'b0, cnt_new};
                    unique case (dec.region)
                        mmau_pkg::REGION_ROM:
                        begin
                            if (is_write)
                            begin
                                res_comb.status = mmau_pkg::STATUS_BAD_STORE;
                            end
                            else
                            begin
                                res_comb.read_data = rom_rdata;
                            end
                        end
                        mmau_pkg::REGION_FIXED:
                        begin
                            if (is_write)
                            begin
                                res_comb.status = mmau_pkg::STATUS_BAD_STORE;
                            end
                            else
                            begin
                                res_comb.read_data = mmau_pkg::ERASED_BYTE;
                            end
                        end
                        mmau_pkg::REGION_RAM:
                        begin
                            if (is_write)
                            begin
                                ram_wr_req = 1'b1;
                            end
                            else
                            begin
                                res_comb.read_data = ram_rdata;
                            end
                        end
                        mmau_pkg::REGION_SFR:
                        begin
                            if (item_reg.exec_access)
                            begin
                                res_comb.status = mmau_pkg::STATUS_BAD_EXEC;
                            end
                            else
                            begin
                                res_comb.status         = mmau_pkg::STATUS_FORWARD;
                                res_comb.periph_address = item_reg.address[8:0]
                                                          & mmau_pkg::SFR_MASK;
                                res_comb.periph_write   = is_write;
                                res_comb.periph_word    = item_reg.word_access;
                                res_comb.periph_data    = is_write ? item_reg.write_data
                                                                   : 8'h00;
                            end
                        end
                        mmau_pkg::REGION_NODEV:
                        begin
                            res_comb.status = mmau_pkg::STATUS_NO_DEV;
                        end
                        default:
                        begin
                            res_comb.status = mmau_pkg::STATUS_NO_DEV;
                        end
                    endcase
                end
            end
        endcase
        res_comb.access_count = cnt_wide[31:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmau_pkg::S_CLEAR:
            begin
                if (clear_cnt_reg == 16'hFFFF)
                begin
                    state_next = mmau_pkg::S_IDLE;
                end
            end
            mmau_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = mmau_pkg::S_LOOKUP;
                end
            end
            mmau_pkg::S_LOOKUP:
            begin
                state_next = rsp_free ? mmau_pkg::S_IDLE : mmau_pkg::S_HOLD;
            end
            mmau_pkg::S_HOLD:
            begin
                if (rsp_free)
                begin
                    state_next = mmau_pkg::S_IDLE;
                end
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        req_stall     = 1'b1;
        prof_we       = 1'b0;
        prof_wdata    = prof_wr_data;
        rom_we        = 1'b0;
        ram_we        = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next = rsp_word_reg;
        res_next      = res_reg;
        unique case (state_reg)
            mmau_pkg::S_CLEAR:
            begin
                prof_we    = 1'b1;
                prof_wdata = '0;
            end
            mmau_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
            end
            mmau_pkg::S_LOOKUP:
            begin
                prof_we  = prof_wr_req;
                rom_we   = rom_wr_req;
                ram_we   = ram_wr_req;
                res_next = res_comb;
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = res_comb;
                end
            end
            mmau_pkg::S_HOLD:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = res_reg;
                end
            end
        endcase
    end

    assign prof_en = req_accept || prof_we;
    assign rom_en  = req_accept || rom_we;
    assign ram_en  = req_accept || ram_we;

    assign clear_cnt_next      = (state_reg == mmau_pkg::S_CLEAR) ? clear_cnt_reg + 16'd1
                                                                  : clear_cnt_reg;
    assign profile_enable_next = (cfg_valid && cfg_ready) ? cfg_data : profile_enable_reg;
    assign item_next           = req_accept ? req_word : item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= mmau_pkg::S_CLEAR;
            clear_cnt_reg      <= 16'd0;
            profile_enable_reg <= 1'b0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            clear_cnt_reg      <= clear_cnt_next;
            profile_enable_reg <= profile_enable_next;
            rsp_valid_reg      <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        rsp_word_reg <= rsp_word_next;
    end

endmodule

### src/mmau_checker.sv
module mmau_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input mmau_pkg::rsp_t rsp_word
);

    // a response is never dropped while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // one request at a time: busy right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in flight");

    // read data only on a successful read
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status != mmau_pkg::STATUS_OK |-> rsp_word.read_data == 8'h00)
        else $error("read data on failed access");

    // peripheral fields only on a forwarded access
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status != mmau_pkg::STATUS_FORWARD |->
            rsp_word.periph_address == 9'd0 && !rsp_word.periph_write &&
            !rsp_word.periph_word && rsp_word.periph_data == 8'h00)
        else $error("peripheral fields set on local access");

endmodule

bind memory_map_access_unit mmau_checker u_mmau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);
